// ----- hdl/ray_triangle_hit_test_defines.svh -----
`ifndef RAY_TRIANGLE_HIT_TEST_DEFINES_SVH
`define RAY_TRIANGLE_HIT_TEST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RTH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray triangle hit test check failed");

// next-cycle implication, disabled in reset
`define RTH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray triangle hit test check failed");

`endif

// ----- hdl/rth_pkg.sv -----
package rth_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;

    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SQRT_IN_W = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W    = SQRT_IN_W / 2;
    localparam int PP_W      = 2 * DIFF_W;
    localparam int P_W       = PP_W + 2;
    localparam int U_W       = FRAC_BITS + 2;
    localparam int CP_W      = DIFF_W + U_W;
    localparam int C_W       = CP_W + 1;
    localparam int DOT_A_W   = DIFF_W + 1;
    localparam int DOT_B_W   = P_W;
    localparam int DOT_HALF  = DOT_B_W / 2;
    localparam int DOT_W     = DOT_A_W + DOT_B_W + 4;
    localparam int DIST_W    = 31;
    localparam int QUO_W     = DIST_W + 1;
    localparam int DEN_W     = DIFF_W + C_W + 3;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int BARY_W    = FRAC_BITS + 1;
    localparam int EPS_W     = 16;
    localparam int CFG_W     = COORD_W;
    localparam int CFG_IDX_W = 3;

    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int DOT_LAT   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_T_MIN       = 3'd4;

    localparam logic [EPS_W-1:0] DET_EPS_RST = 16'd7;
    localparam logic [EPS_W-1:0] T_MIN_RST   = 16'd66;

    localparam logic [BARY_W-1:0] BARY_ONE = BARY_W'(1) << FRAC_BITS;
    localparam logic [QUO_W-1:0]  DIST_MAX = QUO_W'(32'h7FFF_FFFF);

    typedef struct packed {
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_a_z;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_b_z;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
        logic signed [COORD_W-1:0] vert_c_z;
    } t_ray_in;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [BARY_W-1:0] bary_beta;
        logic [BARY_W-1:0] bary_gamma;
    } t_hit_out;

endpackage

// ----- hdl/rth_sqrt.sv -----
module rth_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [rth_pkg::SQRT_IN_W-1:0]  i_x,
    output logic [rth_pkg::ROOT_W-1:0]     o_root
);
    import rth_pkg::*;

    localparam int OP_W = SQRT_IN_W + 2;

    logic [OP_W-1:0] r_op  [ROOT_W];
    logic [OP_W-1:0] r_res [ROOT_W];
    logic [OP_W-1:0] n_op  [ROOT_W];
    logic [OP_W-1:0] n_res [ROOT_W];

    // one result bit per stage, bit weight fixed by the stage
    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam logic [OP_W-1:0] BIT = OP_W'(1) << (2 * (ROOT_W - 1 - g));
        logic [OP_W-1:0] w_op;
        logic [OP_W-1:0] w_res;
        logic [OP_W-1:0] w_try;

        if (g == 0) begin : g_first
            assign w_op  = OP_W'(i_x);
            assign w_res = '0;
        end else begin : g_next
            assign w_op  = r_op[g-1];
            assign w_res = r_res[g-1];
        end

        assign w_try = w_res + BIT;

        always_comb begin
            if (w_op >= w_try) begin
                n_op[g]  = w_op - w_try;
                n_res[g] = (w_res >> 1) + BIT;
            end else begin
                n_op[g]  = w_op;
                n_res[g] = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_op[g]  <= n_op[g];
                r_res[g] <= n_res[g];
            end
        end
    end

    assign o_root = r_res[ROOT_W-1][ROOT_W-1:0];

endmodule

// ----- hdl/rth_div.sv -----
module rth_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rth_pkg::NUM_W-1:0]  i_num,
    input  logic [rth_pkg::DEN_W-1:0]  i_den,
    output logic [rth_pkg::QUO_W-1:0]  o_quo,
    output logic                       o_ovf
);
    import rth_pkg::*;

    logic [NUM_W-1:0] r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_quo [QUO_W+1];
    logic             r_ovf [QUO_W+1];

    // quotient would need more bits than kept
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= i_num >= {i_den, QUO_W'(0)};
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        localparam int K = QUO_W - 1 - g;
        logic [NUM_W-1:0] w_sub;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        assign w_sub = NUM_W'(r_den[g]) << K;

        always_comb begin
            n_rem = r_rem[g];
            n_quo = r_quo[g];
            if (r_rem[g] >= w_sub) begin
                n_rem    = r_rem[g] - w_sub;
                n_quo[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= n_rem;
                r_den[g+1] <= r_den[g];
                r_quo[g+1] <= n_quo;
                r_ovf[g+1] <= r_ovf[g];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule

// ----- hdl/rth_dot.sv -----
module rth_dot (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [rth_pkg::DOT_A_W-1:0]  i_a [3],
    input  logic signed [rth_pkg::DOT_B_W-1:0]  i_b [3],
    output logic signed [rth_pkg::DOT_W-1:0]    o_sum
);
    import rth_pkg::*;

    localparam int PLO_W = DOT_A_W + DOT_HALF + 1;
    localparam int PHI_W = DOT_A_W + DOT_B_W - DOT_HALF;

    logic signed [PLO_W-1:0] r_plo  [3];
    logic signed [PHI_W-1:0] r_phi  [3];
    logic signed [PLO_W-1:0] n_plo  [3];
    logic signed [PHI_W-1:0] n_phi  [3];
    logic signed [DOT_W-1:0] r_prod [3];
    logic signed [DOT_W-1:0] n_prod [3];
    logic signed [DOT_W-1:0] r_s01;
    logic signed [DOT_W-1:0] r_p2;
    logic signed [DOT_W-1:0] r_sum;

    // wide operand split in two halves, partial products registered
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_plo[j] = PLO_W'(i_a[j]) * PLO_W'($signed({1'b0, i_b[j][DOT_HALF-1:0]}));
            n_phi[j] = PHI_W'(i_a[j]) * PHI_W'($signed(i_b[j][DOT_B_W-1:DOT_HALF]));
            n_prod[j] = (DOT_W'(r_phi[j]) <<< DOT_HALF) + DOT_W'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_plo[j]  <= n_plo[j];
                r_phi[j]  <= n_phi[j];
                r_prod[j] <= n_prod[j];
            end
            r_s01 <= r_prod[0] + r_prod[1];
            r_p2  <= r_prod[2];
            r_sum <= r_s01 + r_p2;
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- hdl/ray_triangle_hit_test.sv -----
// Ray/triangle hit test by Cramer's rule on signed Q16.16 data. One test
// (direction plus three vertices) is taken every clock unless the pipe holds,
// and one result leaves per test, in order. The pipe is built from the fully
// pipelined units: a 48-stage square root for the direction length, two banks
// of three 33-stage restoring dividers (unit direction, then t/beta/gamma) and
// four 4-stage split-multiplier dot products. The whole pipe holds while a
// result waits at the output under stall; o_stall is high only then. The ray
// origin, determinant threshold and minimum distance come from the write port;
// the user must change them only while no test is in flight (not enforced).
module ray_triangle_hit_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  rth_pkg::t_ray_in                i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output rth_pkg::t_hit_out               o_data,
    input  logic                            i_cfg_we,
    input  logic [rth_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rth_pkg::CFG_W-1:0]       i_cfg_data
);
    import rth_pkg::*;

    typedef struct packed {
        logic                          valid;
        logic                          dzero;
        logic [2:0]                    dneg;
        logic [2:0][COORD_W-1:0]       dmag;
        logic [2:0][DIFF_W-1:0]        ab;
        logic [2:0][DIFF_W-1:0]        ac;
        logic [2:0][DIFF_W-1:0]        ao;
        logic [2:0][P_W-1:0]           p;
    } t_side_a;

    typedef struct packed {
        logic                          valid;
        logic                          dzero;
        logic [2:0][U_W-1:0]           u;
        logic [2:0][DIFF_W-1:0]        ab;
        logic [2:0][DIFF_W-1:0]        ac;
        logic [2:0][DIFF_W-1:0]        ao;
        logic [2:0][P_W-1:0]           p;
    } t_side_c;

    typedef struct packed {
        logic valid;
        logic dzero;
    } t_side_d;

    typedef struct packed {
        logic valid;
        logic miss;
        logic t_flip;
        logic g_flip;
        logic b_flip;
    } t_side_e;

    logic w_en;

    logic signed [COORD_W-1:0] r_org [3];
    logic [EPS_W-1:0]          r_det_eps;
    logic [EPS_W-1:0]          r_t_min;

    logic signed [COORD_W-1:0] w_dir [3];
    logic signed [COORD_W-1:0] w_va  [3];
    logic signed [COORD_W-1:0] w_vb  [3];
    logic signed [COORD_W-1:0] w_vc  [3];

    logic                      r1_valid;
    logic [2:0]                r1_dneg;
    logic [COORD_W-1:0]        r1_dmag [3];
    logic [SQ_W-1:0]           r1_sq   [3];
    logic signed [DIFF_W-1:0]  r1_ab   [3];
    logic signed [DIFF_W-1:0]  r1_ac   [3];
    logic signed [DIFF_W-1:0]  r1_ao   [3];
    logic [COORD_W-1:0]        n1_dmag [3];
    logic [SQ_W-1:0]           n1_sq   [3];
    logic signed [DIFF_W-1:0]  n1_ab   [3];
    logic signed [DIFF_W-1:0]  n1_ac   [3];
    logic signed [DIFF_W-1:0]  n1_ao   [3];

    logic                      r2_valid;
    logic [2:0]                r2_dneg;
    logic [COORD_W-1:0]        r2_dmag [3];
    logic [SQ_W-1:0]           r2_sq;
    logic signed [PP_W-1:0]    r2_pp   [6];
    logic signed [PP_W-1:0]    n2_pp   [6];
    logic signed [DIFF_W-1:0]  r2_ab   [3];
    logic signed [DIFF_W-1:0]  r2_ac   [3];
    logic signed [DIFF_W-1:0]  r2_ao   [3];

    t_side_a                   r3_side;
    t_side_a                   n3_side;
    logic [SQRT_IN_W-1:0]      r3_x;
    t_side_a                   r_sa [SQRT_LAT];
    logic [ROOT_W-1:0]         w_root;
    t_side_a                   r_sb [DIV_LAT];
    logic [QUO_W-1:0]          w_uq   [3];
    logic                      w_uovf [3];

    t_side_c                   r5_side;
    t_side_c                   n5_side;
    t_side_c                   r6_side;
    logic signed [CP_W-1:0]    r6_cp [6];
    logic signed [CP_W-1:0]    n6_cp [6];
    t_side_c                   r7_side;
    logic signed [C_W-1:0]     r7_c  [3];

    logic signed [DOT_A_W-1:0] w_det_a [3];
    logic signed [DOT_B_W-1:0] w_det_b [3];
    logic signed [DOT_A_W-1:0] w_nt_a  [3];
    logic signed [DOT_B_W-1:0] w_nt_b  [3];
    logic signed [DOT_A_W-1:0] w_ng_a  [3];
    logic signed [DOT_B_W-1:0] w_ng_b  [3];
    logic signed [DOT_A_W-1:0] w_nb_a  [3];
    logic signed [DOT_B_W-1:0] w_nb_b  [3];
    logic signed [DOT_W-1:0]   w_det;
    logic signed [DOT_W-1:0]   w_nt;
    logic signed [DOT_W-1:0]   w_ng;
    logic signed [DOT_W-1:0]   w_nb;
    t_side_d                   r_sd [DOT_LAT];

    t_side_e                   r8_side;
    t_side_e                   n8_side;
    logic [DEN_W-1:0]          r8_den;
    logic [DEN_W-1:0]          n8_den;
    logic [NUM_W-1:0]          r8_num [3];
    logic [NUM_W-1:0]          n8_num [3];
    t_side_e                   r_se [DIV_LAT];
    logic [QUO_W-1:0]          w_rq   [3];
    logic                      w_rovf [3];

    logic                      r_out_valid;
    t_hit_out                  r_out;
    t_hit_out                  n_out;

    // whole pipe advances unless the output transfer is held
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_det_eps <= DET_EPS_RST;
            r_t_min   <= T_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_X:    r_org[0]  <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_ORIGIN_Y:    r_org[1]  <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_ORIGIN_Z:    r_org[2]  <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_DET_EPSILON: r_det_eps <= i_cfg_data[EPS_W-1:0];
                REG_T_MIN:       r_t_min   <= i_cfg_data[EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_dir[0] = i_data.dir_x;
    assign w_dir[1] = i_data.dir_y;
    assign w_dir[2] = i_data.dir_z;
    assign w_va[0]  = i_data.vert_a_x;
    assign w_va[1]  = i_data.vert_a_y;
    assign w_va[2]  = i_data.vert_a_z;
    assign w_vb[0]  = i_data.vert_b_x;
    assign w_vb[1]  = i_data.vert_b_y;
    assign w_vb[2]  = i_data.vert_b_z;
    assign w_vc[0]  = i_data.vert_c_x;
    assign w_vc[1]  = i_data.vert_c_y;
    assign w_vc[2]  = i_data.vert_c_z;

    // squares, magnitudes and edge/offset vectors
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_dmag[i] = w_dir[i][COORD_W-1] ? COORD_W'(-w_dir[i]) : COORD_W'(w_dir[i]);
            n1_sq[i]   = SQ_W'(SQ_W'(w_dir[i]) * SQ_W'(w_dir[i]));
            n1_ab[i]   = DIFF_W'(w_va[i]) - DIFF_W'(w_vb[i]);
            n1_ac[i]   = DIFF_W'(w_va[i]) - DIFF_W'(w_vc[i]);
            n1_ao[i]   = DIFF_W'(w_va[i]) - DIFF_W'(r_org[i]);
        end
    end

    // products for the offset-edge cross product
    always_comb begin
        n2_pp[0] = PP_W'(r1_ab[0]) * PP_W'(r1_ao[1]);
        n2_pp[1] = PP_W'(r1_ao[0]) * PP_W'(r1_ab[1]);
        n2_pp[2] = PP_W'(r1_ao[0]) * PP_W'(r1_ab[2]);
        n2_pp[3] = PP_W'(r1_ab[0]) * PP_W'(r1_ao[2]);
        n2_pp[4] = PP_W'(r1_ab[1]) * PP_W'(r1_ao[2]);
        n2_pp[5] = PP_W'(r1_ao[1]) * PP_W'(r1_ab[2]);
    end

    always_comb begin
        n3_side.valid = r2_valid;
        n3_side.dzero = r2_sq == '0;
        n3_side.dneg  = r2_dneg;
        for (int i = 0; i < 3; i++) begin
            n3_side.dmag[i] = r2_dmag[i];
            n3_side.ab[i]   = r2_ab[i];
            n3_side.ac[i]   = r2_ac[i];
            n3_side.ao[i]   = r2_ao[i];
            n3_side.p[i]    = P_W'(r2_pp[2*i]) - P_W'(r2_pp[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_side     <= '0;
            for (int i = 0; i < SQRT_LAT; i++) begin
                r_sa[i] <= '0;
            end
            for (int i = 0; i < DIV_LAT; i++) begin
                r_sb[i] <= '0;
            end
        end else if (w_en) begin
            r1_valid <= i_valid;
            r1_dneg  <= {w_dir[2][COORD_W-1], w_dir[1][COORD_W-1], w_dir[0][COORD_W-1]};
            r2_valid <= r1_valid;
            r2_dneg  <= r1_dneg;
            r2_sq    <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            for (int i = 0; i < 3; i++) begin
                r1_dmag[i] <= n1_dmag[i];
                r1_sq[i]   <= n1_sq[i];
                r1_ab[i]   <= n1_ab[i];
                r1_ac[i]   <= n1_ac[i];
                r1_ao[i]   <= n1_ao[i];
                r2_dmag[i] <= r1_dmag[i];
                r2_ab[i]   <= r1_ab[i];
                r2_ac[i]   <= r1_ac[i];
                r2_ao[i]   <= r1_ao[i];
            end
            for (int i = 0; i < 6; i++) begin
                r2_pp[i] <= n2_pp[i];
            end
            r3_side <= n3_side;
            r3_x    <= SQRT_IN_W'(r2_sq) << (2 * FRAC_BITS);
            r_sa[0] <= r3_side;
            for (int i = 1; i < SQRT_LAT; i++) begin
                r_sa[i] <= r_sa[i-1];
            end
            r_sb[0] <= r_sa[SQRT_LAT-1];
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    rth_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r3_x),
        .o_root (w_root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_udiv
        rth_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (NUM_W'(r_sa[SQRT_LAT-1].dmag[g]) << (2 * FRAC_BITS)),
            .i_den (DEN_W'(w_root)),
            .o_quo (w_uq[g]),
            .o_ovf (w_uovf[g])
        );
    end

    // unit direction; its magnitude never exceeds one, but a zero direction sets the overflow flag, which joins dzero
    always_comb begin
        n5_side.valid = r_sb[DIV_LAT-1].valid;
        n5_side.dzero = r_sb[DIV_LAT-1].dzero || w_uovf[0] || w_uovf[1] || w_uovf[2];
        n5_side.ab    = r_sb[DIV_LAT-1].ab;
        n5_side.ac    = r_sb[DIV_LAT-1].ac;
        n5_side.ao    = r_sb[DIV_LAT-1].ao;
        n5_side.p     = r_sb[DIV_LAT-1].p;
        for (int i = 0; i < 3; i++) begin
            n5_side.u[i] = r_sb[DIV_LAT-1].dneg[i] ? -w_uq[i][U_W-1:0] : w_uq[i][U_W-1:0];
        end
    end

    always_comb begin
        logic signed [DIFF_W-1:0] ac [3];
        logic signed [U_W-1:0]    u  [3];
        for (int i = 0; i < 3; i++) begin
            ac[i] = $signed(r5_side.ac[i]);
            u[i]  = $signed(r5_side.u[i]);
        end
        n6_cp[0] = CP_W'(ac[1]) * CP_W'(u[2]);
        n6_cp[1] = CP_W'(u[1])  * CP_W'(ac[2]);
        n6_cp[2] = CP_W'(u[0])  * CP_W'(ac[2]);
        n6_cp[3] = CP_W'(ac[0]) * CP_W'(u[2]);
        n6_cp[4] = CP_W'(ac[0]) * CP_W'(u[1]);
        n6_cp[5] = CP_W'(ac[1]) * CP_W'(u[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side <= '0;
            r6_side <= '0;
            r7_side <= '0;
        end else if (w_en) begin
            r5_side <= n5_side;
            r6_side <= r5_side;
            r7_side <= r6_side;
            for (int i = 0; i < 6; i++) begin
                r6_cp[i] <= n6_cp[i];
            end
            for (int i = 0; i < 3; i++) begin
                r7_c[i] <= C_W'(r6_cp[2*i]) - C_W'(r6_cp[2*i+1]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_det_a[i] = DOT_A_W'($signed(r7_side.ab[i]));
            w_det_b[i] = DOT_B_W'(r7_c[i]);
            w_nt_a[i]  = DOT_A_W'($signed(r7_side.ac[2-i]));
            w_nt_b[i]  = DOT_B_W'($signed(r7_side.p[i]));
            w_ng_a[i]  = DOT_A_W'($signed(r7_side.u[2-i]));
            w_ng_b[i]  = DOT_B_W'($signed(r7_side.p[i]));
            w_nb_a[i]  = DOT_A_W'($signed(r7_side.ao[i]));
            w_nb_b[i]  = DOT_B_W'(r7_c[i]);
        end
    end

    rth_dot u_dot_det (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_det_a), .i_b (w_det_b), .o_sum (w_det)
    );
    rth_dot u_dot_t (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_nt_a), .i_b (w_nt_b), .o_sum (w_nt)
    );
    rth_dot u_dot_g (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_ng_a), .i_b (w_ng_b), .o_sum (w_ng)
    );
    rth_dot u_dot_b (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_nb_a), .i_b (w_nb_b), .o_sum (w_nb)
    );

    // determinant tests and quotient magnitudes; t takes the negated numerator
    always_comb begin
        logic             det_neg;
        logic [DOT_W-1:0] det_mag;
        logic [DOT_W-1:0] nt_mag;
        logic [DOT_W-1:0] ng_mag;
        logic [DOT_W-1:0] nb_mag;
        logic             nt_pos;
        det_neg = w_det[DOT_W-1];
        det_mag = det_neg ? DOT_W'(-w_det) : DOT_W'(w_det);
        nt_mag  = w_nt[DOT_W-1] ? DOT_W'(-w_nt) : DOT_W'(w_nt);
        ng_mag  = w_ng[DOT_W-1] ? DOT_W'(-w_ng) : DOT_W'(w_ng);
        nb_mag  = w_nb[DOT_W-1] ? DOT_W'(-w_nb) : DOT_W'(w_nb);
        nt_pos  = !w_nt[DOT_W-1] && (w_nt != '0);
        n8_den  = det_mag[DEN_W-1:0];
        n8_side.valid  = r_sd[DOT_LAT-1].valid;
        n8_side.miss   = r_sd[DOT_LAT-1].dzero || (w_det == '0)
                       || (n8_den < (DEN_W'(r_det_eps) << (2 * FRAC_BITS)));
        n8_side.t_flip = nt_pos ^ det_neg;
        n8_side.g_flip = w_ng[DOT_W-1] ^ det_neg;
        n8_side.b_flip = w_nb[DOT_W-1] ^ det_neg;
        n8_num[0] = NUM_W'(nt_mag[NUM_W-FRAC_BITS-1:0]) << FRAC_BITS;
        n8_num[1] = NUM_W'(ng_mag[NUM_W-FRAC_BITS-1:0]) << FRAC_BITS;
        n8_num[2] = NUM_W'(nb_mag[NUM_W-FRAC_BITS-1:0]) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DOT_LAT; i++) begin
                r_sd[i] <= '0;
            end
            r8_side <= '0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_se[i] <= '0;
            end
        end else if (w_en) begin
            r_sd[0] <= {r7_side.valid, r7_side.dzero};
            for (int i = 1; i < DOT_LAT; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r8_side <= n8_side;
            r8_den  <= n8_den;
            for (int i = 0; i < 3; i++) begin
                r8_num[i] <= n8_num[i];
            end
            r_se[0] <= r8_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_se[i] <= r_se[i-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_rdiv
        rth_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r8_num[g]),
            .i_den (r8_den),
            .o_quo (w_rq[g]),
            .o_ovf (w_rovf[g])
        );
    end

    // range tests on the truncated quotients
    always_comb begin
        logic              t_low;
        logic              g_bad;
        logic              b_bad;
        logic              hit;
        logic [BARY_W-1:0] g_val;
        logic [BARY_W-1:0] b_lim;
        t_low = (r_se[DIV_LAT-1].t_flip && (w_rovf[0] || w_rq[0] != '0))
              || (!w_rovf[0] && (w_rq[0] < QUO_W'(r_t_min)));
        g_bad = (r_se[DIV_LAT-1].g_flip && (w_rovf[1] || w_rq[1] != '0))
              || w_rovf[1] || (w_rq[1] > QUO_W'(BARY_ONE));
        g_val = w_rq[1][BARY_W-1:0];
        b_lim = BARY_ONE - g_val;
        b_bad = (r_se[DIV_LAT-1].b_flip && (w_rovf[2] || w_rq[2] != '0))
              || w_rovf[2] || (w_rq[2] > QUO_W'(b_lim));
        hit   = !r_se[DIV_LAT-1].miss && !t_low && !g_bad && !b_bad;
        n_out = '0;
        if (hit) begin
            n_out.hit        = 1'b1;
            n_out.distance   = (w_rovf[0] || w_rq[0] > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
                                                                 : w_rq[0][DIST_W-1:0];
            n_out.bary_beta  = w_rq[2][BARY_W-1:0];
            n_out.bary_gamma = g_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_se[DIV_LAT-1].valid;
            r_out       <= n_out;
        end
    end

endmodule

// ----- hdl/rth_chk.sv -----
`include "ray_triangle_hit_test_defines.svh"

module rth_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_stall,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  rth_pkg::t_hit_out               o_data
);
    import rth_pkg::*;

    logic [BARY_W:0] w_bsum;
    logic            w_miss;
    logic            w_hit;
    logic            w_zero;

    assign w_bsum = (BARY_W + 1)'(o_data.bary_beta) + (BARY_W + 1)'(o_data.bary_gamma);
    assign w_miss = o_valid && !o_data.hit;
    assign w_hit  = o_valid && o_data.hit;
    assign w_zero = o_data.distance == '0 && o_data.bary_beta == '0
                 && o_data.bary_gamma == '0;

    `RTH_ASSERT_NXT(a_out_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `RTH_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, w_miss, w_zero)
    `RTH_ASSERT_IMP(a_bary_sum, i_clk, i_rst_n, w_hit, w_bsum <= (BARY_W + 1)'(BARY_ONE))
    `RTH_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

bind ray_triangle_hit_test rth_chk u_rth_chk (.*);
